/* sv/sldf_pkg.sv */
`default_nettype none

package sldf_pkg;

   // Sync word, first byte on the link first
   localparam int unsigned SYNC_BYTES = 4;
   localparam logic [7:0] SYNC_WORD [SYNC_BYTES] = '{8'hDE, 8'hAD, 8'hBE, 8'hEF};
   localparam logic [1:0] SYNC_LAST_INDEX = 2'(SYNC_BYTES - 1);

   // Header bytes that carry the payload length, little endian
   localparam logic [15:0] LEN_LOW_INDEX  = 16'd4;
   localparam logic [15:0] LEN_HIGH_INDEX = 16'd5;

   // Depth of the queue between the classifier and the output stage
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_TOO_LONG  = 1'b1;

   // One result word
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       in_header;
      logic       frame_end;
      logic       status;
   } rsp_word_type;

endpackage

`default_nettype wire

/* sv/sldf_front.sv */
`default_nettype none

module sldf_front #(
   parameter int unsigned HEADER_BYTES = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            rx_byte,
   input  wire logic                  cfg_write,
   input  wire logic [15:0]           cfg_max_len,
   output logic                       word_valid,
   output sldf_pkg::rsp_word_type     word
);

   typedef enum logic [1:0] {
      PH_SYNC    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   localparam logic [15:0] HDR_LAST = 16'(HEADER_BYTES - 1);

   phase_type   phase_ff, phase_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] payload_length_ff, payload_length_in;
   logic [15:0] max_len_ff;
   logic [15:0] len_now;
   logic [16:0] next_count;

   // Merge the incoming length byte into the stored length
   always_comb begin
      len_now = payload_length_ff;
      if (byte_count_ff == sldf_pkg::LEN_LOW_INDEX) begin
         len_now = {payload_length_ff[15:8], rx_byte};
      end else if (byte_count_ff == sldf_pkg::LEN_HIGH_INDEX) begin
         len_now = {rx_byte, payload_length_ff[7:0]};
      end
   end

   assign next_count = {1'b0, byte_count_ff} + 17'd1;

   // Classify the byte and advance the frame state
   always_comb begin
      phase_in          = phase_ff;
      byte_count_in     = byte_count_ff;
      payload_length_in = payload_length_ff;
      word_valid        = 1'b0;
      word.frame_byte   = rx_byte;
      word.in_header    = 1'b0;
      word.frame_end    = 1'b0;
      word.status       = sldf_pkg::STATUS_OK;
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               payload_length_in = len_now;
               word_valid        = 1'b1;
               word.in_header    = 1'b1;
               if (byte_count_ff >= HDR_LAST) begin
                  byte_count_in = '0;
                  if (len_now > max_len_ff) begin
                     phase_in       = PH_SYNC;
                     word.frame_end = 1'b1;
                     word.status    = sldf_pkg::STATUS_TOO_LONG;
                  end else if (len_now == 16'd0) begin
                     phase_in       = PH_SYNC;
                     word.frame_end = 1'b1;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  byte_count_in = next_count[15:0];
               end
            end
            PH_PAYLOAD: begin
               word_valid = 1'b1;
               if (next_count >= {1'b0, payload_length_ff}) begin
                  phase_in       = PH_SYNC;
                  byte_count_in  = '0;
                  word.frame_end = 1'b1;
               end else begin
                  byte_count_in = next_count[15:0];
               end
            end
            default: begin
               // Hunt for the sync word; a mismatch restarts the hunt
               if (rx_byte == sldf_pkg::SYNC_WORD[byte_count_ff[1:0]]) begin
                  if (byte_count_ff[1:0] == sldf_pkg::SYNC_LAST_INDEX) begin
                     phase_in          = PH_HEADER;
                     byte_count_in     = '0;
                     payload_length_in = '0;
                  end else begin
                     byte_count_in = next_count[15:0];
                  end
               end else begin
                  phase_in      = PH_SYNC;
                  byte_count_in = '0;
               end
            end
         endcase
      end
   end

   // Hold frame state and the length limit
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_SYNC;
         byte_count_ff     <= '0;
         payload_length_ff <= '0;
         max_len_ff        <= 16'd1024;
      end else begin
         phase_ff          <= phase_in;
         byte_count_ff     <= byte_count_in;
         payload_length_ff <= payload_length_in;
         if (cfg_write) begin
            max_len_ff <= cfg_max_len;
         end
      end
   end

   a_status_ends_header: assert property (@(posedge clock) disable iff (reset)
      (word_valid && word.status) |-> (word.frame_end && word.in_header))
      else $error("error status on a word that does not end the header");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (payload_length_ff != 16'd0))
      else $error("payload phase with zero length");

   a_sync_count_small: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SYNC) |-> (byte_count_ff < 16'(sldf_pkg::SYNC_BYTES)))
      else $error("sync hunt index out of range");

endmodule

`default_nettype wire

/* sv/sldf_queue.sv */
`default_nettype none

module sldf_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire sldf_pkg::rsp_word_type push_word,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        head_valid,
   output sldf_pkg::rsp_word_type      head_word
);

   localparam int unsigned PTR_W = $clog2(sldf_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(sldf_pkg::QUEUE_DEPTH + 1);

   sldf_pkg::rsp_word_type store_ff [sldf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(sldf_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_word  = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Write the word store
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_word;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            count_ff <= CNT_W'(count_ff + 1'b1);
         end else if (do_pop && !do_push) begin
            count_ff <= CNT_W'(count_ff - 1'b1);
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(sldf_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("queue count did not grow on push");

endmodule

`default_nettype wire

/* sv/sldf_back.sv */
`default_nettype none

module sldf_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire sldf_pkg::rsp_word_type head_word,
   output logic                        head_pop,
   input  wire logic                   pop,
   output logic                        empty,
   output sldf_pkg::rsp_word_type      out_word
);

   logic                   valid_ff;
   sldf_pkg::rsp_word_type word_ff;

   // Refill the output register when it is free or being drained
   assign head_pop = head_valid && (!valid_ff || pop);
   assign empty    = !valid_ff;
   assign out_word = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (head_pop) begin
         valid_ff <= 1'b1;
      end else if (pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         word_ff <= head_word;
      end
   end

endmodule

`default_nettype wire

/* sv/sync_length_frame_deframer.sv */
// A result word is written into the queue, then into the output register on the rsp_ ports.
// Throughput: one byte per cycle on both sides unless stalled; the classifier takes one
// byte per cycle while req_full is low, and a four-word queue plus an output register decouple it from the result side.
// Sync bytes and dropped bytes produce no result word.
// Reset (synchronous, active high): sync hunt, queue empty, max payload length 1024.
`default_nettype none

module sync_length_frame_deframer #(
   parameter int unsigned HEADER_BYTES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_in_header,
   output logic             rsp_frame_end,
   output logic             rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_max_payload_length
);

   logic                   accept;
   logic                   word_valid;
   sldf_pkg::rsp_word_type word;
   logic                   head_valid;
   logic                   head_pop;
   sldf_pkg::rsp_word_type head_word;
   sldf_pkg::rsp_word_type out_word;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   sldf_front #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .cfg_write   (csr_valid && csr_ready),
      .cfg_max_len (csr_max_payload_length),
      .word_valid  (word_valid),
      .word        (word)
   );

   sldf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (word_valid),
      .push_word  (word),
      .full       (req_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_word  (head_word)
   );

   sldf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_word  (head_word),
      .head_pop   (head_pop),
      .pop        (rsp_pop),
      .empty      (rsp_empty),
      .out_word   (out_word)
   );

   assign rsp_frame_byte = out_word.frame_byte;
   assign rsp_in_header  = out_word.in_header;
   assign rsp_frame_end  = out_word.frame_end;
   assign rsp_status     = out_word.status;

endmodule

`default_nettype wire
